@@ src/tmac_pkg.sv @@
// shared widths, types and helpers for the triangle cosine core
package tmac_pkg;

	localparam int COORD_BITS  = 16;
	localparam int FRAC_BITS   = 14;
	localparam int IN_W        = 16;
	localparam int OUT_W       = 16;
	localparam int NUM_CORNERS = 3;
	localparam int DIMS        = 3;

	localparam int EDGE_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * EDGE_W;
	localparam int LEN_W  = PROD_W + 1;
	localparam int DOT_W  = PROD_W + 2;
	localparam int HALF_W = (LEN_W + 1) / 2;
	localparam int HIGH_W = LEN_W - HALF_W;
	localparam int PP_W   = LEN_W + HALF_W;
	localparam int P_W    = 2 * LEN_W;
	localparam int ACC_W  = P_W + 2 * FRAC_BITS + 5;
	localparam int STEPS  = FRAC_BITS + 1;
	localparam int COS_W  = FRAC_BITS + 2;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	// one corner as handed from the front to the back
	typedef struct packed {
		logic [P_W-1:0] p;
		logic [P_W-1:0] dsq;
		logic           neg;
		logic           zero;
	} corner_job_t;

	typedef corner_job_t [NUM_CORNERS-1:0] tri_job_t;

	// sign extension of a coordinate field from COORD_BITS
	function automatic logic signed [EDGE_W-1:0] coord_ext(input logic [IN_W-1:0] v);
		logic [COORD_BITS-1:0] t;
		t = COORD_BITS'(v);
		return EDGE_W'(signed'(t));
	endfunction

endpackage

@@ src/tmac_front.sv @@
// front pipeline: edge vectors, squared lengths, dot products and wide products
module tmac_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [tmac_pkg::IN_W-1:0] a_x,
	input  logic signed [tmac_pkg::IN_W-1:0] a_y,
	input  logic signed [tmac_pkg::IN_W-1:0] a_z,
	input  logic signed [tmac_pkg::IN_W-1:0] b_x,
	input  logic signed [tmac_pkg::IN_W-1:0] b_y,
	input  logic signed [tmac_pkg::IN_W-1:0] b_z,
	input  logic signed [tmac_pkg::IN_W-1:0] c_x,
	input  logic signed [tmac_pkg::IN_W-1:0] c_y,
	input  logic signed [tmac_pkg::IN_W-1:0] c_z,
	output logic                             job_valid,
	input  logic                             job_ready,
	output tmac_pkg::tri_job_t               job
);
	import tmac_pkg::*;

	logic [IN_W-1:0] raw [NUM_CORNERS][DIMS];
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic signed [EDGE_W-1:0] d_s1   [NUM_CORNERS][DIMS];
	logic signed [PROD_W-1:0] sq_s2  [NUM_CORNERS][DIMS];
	logic signed [PROD_W-1:0] dp_s2  [NUM_CORNERS][DIMS];
	logic        [LEN_W-1:0]  len_s3 [NUM_CORNERS];
	logic signed [DOT_W-1:0]  dot_s3 [NUM_CORNERS];
	logic        [PP_W-1:0]   plo_s4 [NUM_CORNERS];
	logic        [PP_W-1:0]   phi_s4 [NUM_CORNERS];
	logic        [PP_W-1:0]   mlo_s4 [NUM_CORNERS];
	logic        [PP_W-1:0]   mhi_s4 [NUM_CORNERS];
	logic                     neg_s4 [NUM_CORNERS];
	logic                     zero_s4[NUM_CORNERS];
	tri_job_t                 job_s5;

	assign raw[0][0] = a_x;
	assign raw[0][1] = a_y;
	assign raw[0][2] = a_z;
	assign raw[1][0] = b_x;
	assign raw[1][1] = b_y;
	assign raw[1][2] = b_z;
	assign raw[2][0] = c_x;
	assign raw[2][1] = c_y;
	assign raw[2][2] = c_z;

	assign en        = !vld_s5 || job_ready;
	assign in_ready  = en;
	assign job_valid = vld_s5;
	assign job       = job_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	for (genvar e = 0; e < NUM_CORNERS; e++) begin : g_edge
		localparam int EN = (e + 1) % NUM_CORNERS;
		localparam int EP = (e + 2) % NUM_CORNERS;
		logic signed [DOT_W-1:0] dot_mag;
		logic        [LEN_W-1:0] mag;
		logic        [LEN_W-1:0] l1, l2;

		// edge e runs from corner e to the next corner
		for (genvar k = 0; k < DIMS; k++) begin : g_dim
			always_ff @(posedge clk) begin
				if (en) begin
					d_s1[e][k]  <= coord_ext(raw[EN][k]) - coord_ext(raw[e][k]);
					sq_s2[e][k] <= PROD_W'(d_s1[e][k] * d_s1[e][k]);
					dp_s2[e][k] <= PROD_W'(d_s1[e][k] * d_s1[EP][k]);
				end
			end
		end

		assign dot_mag = dot_s3[e] < 0 ? -dot_s3[e] : dot_s3[e];
		assign mag     = LEN_W'($unsigned(dot_mag));
		assign l1      = len_s3[e];
		assign l2      = len_s3[EP];

		always_ff @(posedge clk) begin
			if (en) begin
				len_s3[e] <= LEN_W'($unsigned(sq_s2[e][0])) + LEN_W'($unsigned(sq_s2[e][1]))
					+ LEN_W'($unsigned(sq_s2[e][2]));
				// edge e leaves corner e while edge e-1 points into it, hence the minus
				dot_s3[e] <= -(DOT_W'(dp_s2[e][0]) + DOT_W'(dp_s2[e][1]) + DOT_W'(dp_s2[e][2]));
				plo_s4[e]  <= PP_W'(l1 * l2[HALF_W-1:0]);
				phi_s4[e]  <= PP_W'(l1 * l2[LEN_W-1:HALF_W]);
				mlo_s4[e]  <= PP_W'(mag * mag[HALF_W-1:0]);
				mhi_s4[e]  <= PP_W'(mag * mag[LEN_W-1:HALF_W]);
				neg_s4[e]  <= dot_s3[e] < 0;
				zero_s4[e] <= (l1 == '0) || (l2 == '0);
				job_s5[e].p    <= P_W'(plo_s4[e]) + (P_W'(phi_s4[e]) << HALF_W);
				job_s5[e].dsq  <= P_W'(mlo_s4[e]) + (P_W'(mhi_s4[e]) << HALF_W);
				job_s5[e].neg  <= neg_s4[e];
				job_s5[e].zero <= zero_s4[e];
			end
		end
	end

endmodule

@@ src/tmac_fifo.sv @@
// short queue that decouples the front from the root back end
module tmac_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  tmac_pkg::tri_job_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output tmac_pkg::tri_job_t pop_data
);
	import tmac_pkg::*;

	tri_job_t         slot [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = count_q != CNT_W'(FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/tmac_back.sv @@
// back pipeline: one quotient bit per stage, then sign, maximum and flag
module tmac_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               job_valid,
	output logic                               job_ready,
	input  tmac_pkg::tri_job_t                 job,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic signed [tmac_pkg::OUT_W-1:0]  cos_a,
	output logic signed [tmac_pkg::OUT_W-1:0]  cos_b,
	output logic signed [tmac_pkg::OUT_W-1:0]  cos_c,
	output logic signed [tmac_pkg::OUT_W-1:0]  cos_max,
	output logic                               deg
);
	import tmac_pkg::*;

	localparam logic signed [COS_W-1:0] ONE_C = COS_W'(1) <<< FRAC_BITS;

	logic en;
	logic [STEPS:0] vld_sn;
	logic signed [ACC_W-1:0] acc_sn  [STEPS+1][NUM_CORNERS];
	logic signed [ACC_W-1:0] lin_sn  [STEPS+1][NUM_CORNERS];
	logic signed [ACC_W-1:0] tgt_sn  [STEPS+1][NUM_CORNERS];
	logic        [P_W-1:0]   p_sn    [STEPS+1][NUM_CORNERS];
	logic        [STEPS-1:0] q_sn    [STEPS+1][NUM_CORNERS];
	logic                    neg_sn  [STEPS+1][NUM_CORNERS];
	logic                    zero_sn [STEPS+1][NUM_CORNERS];

	logic signed [COS_W-1:0] cosv [NUM_CORNERS];
	logic signed [COS_W-1:0] mx;
	logic                    flag;
	logic                    res_valid_q;
	logic signed [OUT_W-1:0] cos_a_q, cos_b_q, cos_c_q, cos_max_q;
	logic                    deg_q;

	assign en        = !res_valid_q || res_ready;
	assign job_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn      <= '0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			vld_sn      <= {vld_sn[STEPS-1:0], job_valid};
			res_valid_q <= vld_sn[STEPS];
		end
	end

	for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_corner
		logic signed [ACC_W-1:0] pw0;

		// start from the odd factor -1: acc = P, lin = -P
		assign pw0 = signed'(ACC_W'(job[c].p));

		always_ff @(posedge clk) begin
			if (en) begin
				acc_sn[0][c]  <= pw0;
				lin_sn[0][c]  <= -pw0;
				tgt_sn[0][c]  <= signed'(ACC_W'(job[c].dsq) << (2 * FRAC_BITS + 2));
				p_sn[0][c]    <= job[c].p;
				q_sn[0][c]    <= '0;
				neg_sn[0][c]  <= job[c].neg;
				zero_sn[0][c] <= job[c].zero;
			end
		end

		for (genvar s = 0; s < STEPS; s++) begin : g_step
			localparam int K = FRAC_BITS - s;
			logic signed [ACC_W-1:0] pw, cand;
			logic                    take;

			// acc tracks (2q-1)^2 * P and lin tracks (2q-1) * P
			assign pw   = signed'(ACC_W'(p_sn[s][c]));
			assign cand = acc_sn[s][c] + (lin_sn[s][c] <<< (K + 2)) + (pw <<< (2 * K + 2));
			assign take = cand <= tgt_sn[s][c];

			always_ff @(posedge clk) begin
				if (en) begin
					acc_sn[s+1][c]  <= take ? cand : acc_sn[s][c];
					lin_sn[s+1][c]  <= take ? lin_sn[s][c] + (pw <<< (K + 1)) : lin_sn[s][c];
					q_sn[s+1][c]    <= take ? q_sn[s][c] | (STEPS'(1) << K) : q_sn[s][c];
					tgt_sn[s+1][c]  <= tgt_sn[s][c];
					p_sn[s+1][c]    <= p_sn[s][c];
					neg_sn[s+1][c]  <= neg_sn[s][c];
					zero_sn[s+1][c] <= zero_sn[s][c];
				end
			end
		end

		always_comb begin
			if (zero_sn[STEPS][c]) begin
				cosv[c] = ONE_C;
			end else if (neg_sn[STEPS][c]) begin
				cosv[c] = -signed'(COS_W'(q_sn[STEPS][c]));
			end else begin
				cosv[c] = signed'(COS_W'(q_sn[STEPS][c]));
			end
		end
	end

	always_comb begin
		mx = cosv[0];
		if (cosv[1] > mx) begin
			mx = cosv[1];
		end
		if (cosv[2] > mx) begin
			mx = cosv[2];
		end
		flag = 1'b0;
		for (int c = 0; c < NUM_CORNERS; c++) begin
			if (cosv[c] == ONE_C || cosv[c] == -ONE_C) begin
				flag = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_a_q   <= OUT_W'(cosv[0]);
			cos_b_q   <= OUT_W'(cosv[1]);
			cos_c_q   <= OUT_W'(cosv[2]);
			cos_max_q <= OUT_W'(mx);
			deg_q     <= flag;
		end
	end

	assign res_valid = res_valid_q;
	assign cos_a     = cos_a_q;
	assign cos_b     = cos_b_q;
	assign cos_c     = cos_c_q;
	assign cos_max   = cos_max_q;
	assign deg       = deg_q;

endmodule

@@ src/triangle_min_angle_cosine_core.sv @@
// path from item acceptance to result: front stages, the queue, back stages and an output register
// throughput: one triangle per cycle while the output is not stalled; the back end resolves one cosine bit per stage
// the 4-entry queue soaks up a few front items while the back end is stalled by the output
// reset: arst_n asynchronous, active low; clears all valid flags and queue pointers
// datapath registers are not reset, nothing is shown until an item has passed through
module triangle_min_angle_cosine_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [tmac_pkg::IN_W-1:0]  a_x,
	input  logic signed [tmac_pkg::IN_W-1:0]  a_y,
	input  logic signed [tmac_pkg::IN_W-1:0]  a_z,
	input  logic signed [tmac_pkg::IN_W-1:0]  b_x,
	input  logic signed [tmac_pkg::IN_W-1:0]  b_y,
	input  logic signed [tmac_pkg::IN_W-1:0]  b_z,
	input  logic signed [tmac_pkg::IN_W-1:0]  c_x,
	input  logic signed [tmac_pkg::IN_W-1:0]  c_y,
	input  logic signed [tmac_pkg::IN_W-1:0]  c_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [tmac_pkg::OUT_W-1:0] cos_at_a,
	output logic signed [tmac_pkg::OUT_W-1:0] cos_at_b,
	output logic signed [tmac_pkg::OUT_W-1:0] cos_at_c,
	output logic signed [tmac_pkg::OUT_W-1:0] cos_smallest,
	output logic                              degenerate
);
	import tmac_pkg::*;

	// front to queue
	logic     f_valid, f_ready;
	tri_job_t f_job;
	// queue to back
	logic     b_valid, b_ready;
	tri_job_t b_job;

	// edges, squared lengths, dot products and the two wide products per corner
	tmac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.a_x       (a_x),
		.a_y       (a_y),
		.a_z       (a_z),
		.b_x       (b_x),
		.b_y       (b_y),
		.b_z       (b_z),
		.c_x       (c_x),
		.c_y       (c_y),
		.c_z       (c_z),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	// decoupling queue, each side stalls on its own
	tmac_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_job),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_job)
	);

	// rounded quotient dot/sqrt(P), found bit by bit without a multiplier
	tmac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job       (b_job),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.cos_a     (cos_at_a),
		.cos_b     (cos_at_b),
		.cos_c     (cos_at_c),
		.cos_max   (cos_smallest),
		.deg       (degenerate)
	);

endmodule

@@ src/tmac_checker.sv @@
// port-level checks for the triangle cosine core, bound to the top level
module tmac_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [tmac_pkg::OUT_W-1:0] cos_at_a,
	input logic signed [tmac_pkg::OUT_W-1:0] cos_at_b,
	input logic signed [tmac_pkg::OUT_W-1:0] cos_at_c,
	input logic signed [tmac_pkg::OUT_W-1:0] cos_smallest,
	input logic                              degenerate
);
	import tmac_pkg::*;

	localparam logic signed [OUT_W-1:0] ONE_O = OUT_W'(1) <<< FRAC_BITS;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input item withdrawn before acceptance");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cos_smallest) && $stable(degenerate))
		else $error("result changed while stalled");

	a_max_pick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cos_smallest == cos_at_a || cos_smallest == cos_at_b
			|| cos_smallest == cos_at_c))
		else $error("smallest-angle cosine is not one of the three");

	a_max_ge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cos_smallest >= cos_at_a && cos_smallest >= cos_at_b
			&& cos_smallest >= cos_at_c)
		else $error("smallest-angle cosine below a corner cosine");

	a_deg_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (cos_at_a == ONE_O || cos_at_b == ONE_O || cos_at_c == ONE_O)
			|-> degenerate)
		else $error("unit cosine without degenerate flag");

endmodule

bind triangle_min_angle_cosine_core tmac_checker u_tmac_checker (.*);
